### hw/rtl/gaq_pkg.sv
// Shared constants, register codes and helper functions for the gray adjust quantizer.
package gaq_pkg;

  localparam int PIPE_DEPTH  = 9;
  localparam int DIV_STAGES  = 3;
  localparam int DIV_BPS     = 3;
  localparam int DIV_QBITS   = DIV_STAGES * DIV_BPS;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MIX     = 32'd1274126177;
  localparam int          HASH_SHIFT_A = 13;
  localparam int          HASH_SHIFT_B = 24;

  localparam logic [10:0] FULL_SCALE   = 11'd255;
  localparam logic [10:0] TWO_STEPS    = 11'd510;
  localparam logic [17:0] RECIP_100    = 18'd167773;  // ceil(2^24 / 100)
  localparam int          RECIP_SHIFT  = 24;

  localparam logic       ADJUST_RESET     = 1'b1;
  localparam logic [8:0] CONTRAST_RESET   = 9'd115;
  localparam logic [8:0] BRIGHTNESS_RESET = 9'd0;
  localparam logic       GAMMA_RESET      = 1'b0;

  typedef enum logic [1:0] {
    REG_ADJUST_ENABLE = 2'd0,
    REG_CONTRAST      = 2'd1,
    REG_BRIGHTNESS    = 2'd2,
    REG_GAMMA_ENABLE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] g2;
    logic [7:0] r1;
    logic       app;
    logic [7:0] thr;
    logic       mode;
  } side_t;

  typedef struct packed {
    logic        qbit;
    logic [15:0] rem;
  } div_res_t;

  function automatic logic [7:0] clamp_gray(input logic signed [11:0] v);
    logic [7:0] r;
    if (v < 12'sd0) r = 8'd0;
    else if (v > 12'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  // one restoring step against the divisor shifted left by sh
  function automatic div_res_t div_step(input logic [15:0] rem, input logic [7:0] d,
                                        input logic [3:0] sh);
    logic [16:0] shd;
    div_res_t    r;
    shd = 17'(d) << sh;
    if (17'(rem) >= shd) begin
      r.qbit = 1'b1;
      r.rem  = 16'(17'(rem) - shd);
    end else begin
      r.qbit = 1'b0;
      r.rem  = rem;
    end
    return r;
  endfunction

endpackage

### hw/rtl/gray_adjust_two_bit_quantizer.sv
// Gray adjust and two-bit quantizer: nine-stage pipeline with APB register port.
//
// Input channel in_valid/in_ready carries one pixel per beat: gray_in, pos_x,
// pos_y and mode. Output channel out_valid/out_ready carries one 2-bit level
// per input beat, in input order.
// out_valid is the valid bit of stage 9, the output register.
// Throughput is one pixel per clock while out_ready stays high; the longest
// stage is one 17x18 multiply (divide by 100 through a reciprocal) or one
// 32x32 hash multiply.
// The gamma square root runs as a 9-bit restoring divider spread over three
// stages, 3 quotient bits per stage.
// Each stage holds a valid bit and accepts a new beat when it is empty or its
// successor moves, so bubbles collapse and in_ready stays high while any
// stage is free, even with a result waiting at the output.
// A stalled receiver holds the output beat; the pipe fills and then in_ready
// drops until out_ready returns. Nothing is dropped or repeated.
// Synchronous reset empties the pipe and loads the register defaults:
// adjust on, contrast 115 percent, brightness 0, gamma off.
// Registers are at byte offsets 0x0, 0x4, 0x8, 0xC; write them only while
// the pipe is empty.
module gray_adjust_two_bit_quantizer
  import gaq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  gray_in,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic        mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  level
);

  // configuration
  logic       adjust_enable;
  logic [8:0] contrast_percent;
  logic [8:0] brightness_offset;
  logic       gamma_enable;
  reg_idx_t   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      adjust_enable     <= ADJUST_RESET;
      contrast_percent  <= CONTRAST_RESET;
      brightness_offset <= BRIGHTNESS_RESET;
      gamma_enable      <= GAMMA_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_ADJUST_ENABLE: adjust_enable     <= pwdata[0];
        REG_CONTRAST:      contrast_percent  <= pwdata[8:0];
        REG_BRIGHTNESS:    brightness_offset <= pwdata[8:0];
        REG_GAMMA_ENABLE:  gamma_enable      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ADJUST_ENABLE: prdata = 32'(adjust_enable);
      REG_CONTRAST:      prdata = 32'(contrast_percent);
      REG_BRIGHTNESS:    prdata = 32'(brightness_offset);
      REG_GAMMA_ENABLE:  prdata = 32'(gamma_enable);
      default:           prdata = 32'd0;
    endcase
  end

  // pipeline control
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] adv;

  always_comb begin
    adv[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || out_ready;
    for (int k = PIPE_DEPTH-2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[PIPE_DEPTH-1];

  // stage 1: contrast product, hash partial products
  logic signed [8:0]  d1;
  logic signed [18:0] s1_p;
  logic [31:0]        s1_mx;
  logic [31:0]        s1_my;
  logic [7:0]         s1_gray;
  logic               s1_mode;
  logic [47:0]        mx_full;
  logic [47:0]        my_full;

  always_comb begin
    d1      = $signed({1'b0, gray_in}) - 9'sd128;
    mx_full = 48'(pos_x) * 48'(HASH_MUL_X);
    my_full = 48'(pos_y) * 48'(HASH_MUL_Y);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_p    <= 19'(d1) * $signed({10'd0, contrast_percent});
      s1_mx   <= mx_full[31:0];
      s1_my   <= my_full[31:0];
      s1_gray <= gray_in;
      s1_mode <= mode;
    end
  end

  // stage 2: divide magnitude by 100, hash mix
  logic [18:0] p_abs;
  logic [34:0] q_prod;
  logic [31:0] h0;
  logic [9:0]  s2_qa;
  logic        s2_neg;
  logic [31:0] s2_hm;
  logic [7:0]  s2_gray;
  logic        s2_mode;

  always_comb begin
    p_abs  = s1_p[18] ? 19'(-s1_p) : 19'(s1_p);
    q_prod = 35'(p_abs[16:0]) * 35'(RECIP_100);
    h0     = s1_mx + s1_my;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_qa   <= q_prod[RECIP_SHIFT+9:RECIP_SHIFT];
      s2_neg  <= s1_p[18];
      s2_hm   <= h0 ^ (h0 >> HASH_SHIFT_A);
      s2_gray <= s1_gray;
      s2_mode <= s1_mode;
    end
  end

  // stage 3: contrast and brightness clamps, hash threshold
  logic signed [11:0] q_s;
  logic [7:0]         c_g;
  logic signed [11:0] b_sum;
  logic [63:0]        h_prod;
  logic [7:0]         s3_g2;
  logic [7:0]         s3_thr;
  logic               s3_mode;

  always_comb begin
    q_s    = s2_neg ? -$signed({2'b0, s2_qa}) : $signed({2'b0, s2_qa});
    c_g    = clamp_gray(q_s + 12'sd128);
    b_sum  = $signed({4'b0, c_g}) + 12'($signed(brightness_offset));
    h_prod = 64'(s2_hm) * 64'(HASH_MIX);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_g2   <= adjust_enable ? clamp_gray(b_sum) : s2_gray;
      s3_thr  <= h_prod[HASH_SHIFT_B+7:HASH_SHIFT_B];
      s3_mode <= s2_mode;
    end
  end

  // stage 4: gamma setup, first Newton step is exact ((g + 255) / 2)
  // stages 5..7: restoring divide of g*255 by that estimate
  side_t       dv_side [0:DIV_STAGES];
  logic [15:0] dv_rem  [0:DIV_STAGES];
  logic [DIV_QBITS-1:0] dv_q [0:DIV_STAGES];
  logic        app4;

  assign app4 = adjust_enable && gamma_enable && (s3_g2 != 8'd0);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      dv_side[0].g2   <= s3_g2;
      dv_side[0].r1   <= 8'((9'(s3_g2) + 9'd255) >> 1);
      dv_side[0].app  <= app4;
      dv_side[0].thr  <= s3_thr;
      dv_side[0].mode <= s3_mode;
      dv_rem[0]       <= app4 ? 16'({s3_g2, 8'd0} - 16'(s3_g2)) : 16'd0;
      dv_q[0]         <= '0;
    end
  end

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    logic [15:0]          rem_next;
    logic [DIV_QBITS-1:0] q_next;
    div_res_t             st;

    always_comb begin
      rem_next = dv_rem[j-1];
      q_next   = dv_q[j-1];
      st       = '0;
      for (int b = 0; b < DIV_BPS; b++) begin
        st       = div_step(rem_next, dv_side[j-1].r1,
                            4'(DIV_QBITS - 1 - (j-1)*DIV_BPS - b));
        rem_next = st.rem;
        q_next   = {q_next[DIV_QBITS-2:0], st.qbit};
      end
    end

    always_ff @(posedge clk) begin
      if (adv[3+j]) begin
        dv_side[j] <= dv_side[j-1];
        dv_rem[j]  <= rem_next;
        dv_q[j]    <= q_next;
      end
    end
  end

  // stage 8: second Newton step and gamma clamp
  logic [9:0] r_sum;
  logic [7:0] s8_g;
  logic [7:0] s8_thr;
  logic       s8_mode;
  side_t      sd;

  always_comb begin
    sd    = dv_side[DIV_STAGES];
    r_sum = 10'(sd.r1) + 10'(dv_q[DIV_STAGES]);
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      if (sd.app) s8_g <= r_sum[9] ? 8'd255 : r_sum[8:1];
      else        s8_g <= sd.g2;
      s8_thr  <= sd.thr;
      s8_mode <= sd.mode;
    end
  end

  // stage 9: quantize into the output register
  logic [10:0] s3g;
  logic [10:0] t_lo;
  logic [10:0] t_mid;
  logic [10:0] t_hi;
  logic [1:0]  lvl_next;

  always_comb begin
    s3g   = 11'({s8_g, 1'b0}) + 11'(s8_g);
    t_lo  = s3g + 11'(s8_thr);
    t_mid = s3g - FULL_SCALE + 11'(s8_thr);
    t_hi  = s3g - TWO_STEPS + 11'(s8_thr);
    if (!s8_mode)               lvl_next = s8_g[7:6];
    else if (s3g < FULL_SCALE)  lvl_next = (t_lo  >= FULL_SCALE) ? 2'd1 : 2'd0;
    else if (s3g < TWO_STEPS)   lvl_next = (t_mid >= FULL_SCALE) ? 2'd2 : 2'd1;
    else                        lvl_next = (t_hi  >= FULL_SCALE) ? 2'd3 : 2'd2;
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      level <= lvl_next;
    end
  end

endmodule

### hw/rtl/gaq_checker.sv
// Port-level checker for the gray adjust quantizer, bound to the top level.
module gaq_checker
  import gaq_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] level
);

  logic [3:0] cnt;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 4'(in_beat) - 4'(out_beat);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level))
    else $error("stalled output beat changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cnt != 4'd0)
    else $error("output beat without a pending input");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> cnt == 4'(PIPE_DEPTH))
    else $error("input stalled while pipe has room");

endmodule

bind gray_adjust_two_bit_quantizer gaq_checker u_gaq_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for the gray adjust two-bit quantizer.
`timescale 1ns / 100ps

module tb_top
  import gaq_pkg::*;
();

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          MAX_PRINTS  = 100;
  localparam logic [31:0] MIX_X       = 32'd374761393;
  localparam logic [31:0] MIX_Y       = 32'd668265263;
  localparam logic [31:0] MIX_H       = 32'd1274126177;
  localparam int          SHIFT_A     = 13;
  localparam int          SHIFT_B     = 24;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  gray_in   = '0;
  logic [15:0] pos_x     = '0;
  logic [15:0] pos_y     = '0;
  logic        mode      = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  level;

  // register shadow, reset values
  logic              cfg_adjust   = 1'b1;
  logic [8:0]        cfg_contrast = 9'd115;
  logic signed [8:0] cfg_bright   = 9'sd0;
  logic              cfg_gamma    = 1'b0;

  logic [1:0] level_q[$];
  int         err_cnt   = 0;
  int         cycle_cnt = 0;
  int         ready_hold = 0;
  bit         calm      = 1'b0;

  gray_adjust_two_bit_quantizer i_dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL gray_adjust_two_bit_quantizer");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int clamp8(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic logic [1:0] predict_level(input logic [7:0] g_in, input logic [15:0] x,
                                              input logic [15:0] y, input logic m);
    int          g;
    int          s;
    int          prod;
    int          r;
    int          thr;
    logic [31:0] h;
    logic [1:0]  lvl;
    g = g_in;
    if (cfg_adjust) begin
      g = clamp8(((g - 128) * int'(cfg_contrast)) / 100 + 128);
      g = clamp8(g + int'(cfg_bright));
      if (cfg_gamma && g > 0) begin
        prod = g * 255;
        r = (g + prod / g) >> 1;
        if (r > 0) r = (r + prod / r) >> 1;
        g = (r > 255) ? 255 : r;
      end
    end
    if (!m) begin
      lvl = 2'(g >> 6);
    end else begin
      h = 32'(x) * MIX_X + 32'(y) * MIX_Y;
      h = (h ^ (h >> SHIFT_A)) * MIX_H;
      thr = int'(h >> SHIFT_B);
      s = 3 * g;
      if (s < 255) lvl = (s + thr >= 255) ? 2'd1 : 2'd0;
      else if (s < 510) lvl = (s - 255 + thr >= 255) ? 2'd2 : 2'd1;
      else lvl = (s - 510 + thr >= 255) ? 2'd3 : 2'd2;
    end
    return lvl;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // beat monitor and level check
  always @(posedge clk) begin : level_check
    logic [1:0] exp_lvl;
    if (!rst) begin
      if (in_valid && in_ready)
        level_q.push_back(predict_level(gray_in, pos_x, pos_y, mode));
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          report_mismatch("output beat with no level expected");
        end else begin
          exp_lvl = level_q.pop_front();
          if (level !== exp_lvl)
            report_mismatch($sformatf("level got %0d expected %0d", level, exp_lvl));
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold == 0) begin
      out_ready <= !out_ready;
      ready_hold <= out_ready ? pick_gap() : $urandom_range(0, 12);
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  task automatic send_pixel(input logic [7:0] g, input logic [15:0] x, input logic [15:0] y,
                            input logic m);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    gray_in  <= g;
    pos_x    <= x;
    pos_y    <= y;
    mode     <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ADJUST_ENABLE: cfg_adjust   = val[0];
      REG_CONTRAST:      cfg_contrast = val[8:0];
      REG_BRIGHTNESS:    cfg_bright   = val[8:0];
      REG_GAMMA_ENABLE:  cfg_gamma    = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic ae, input logic [8:0] cp, input logic [8:0] bo,
                            input logic ge);
    drain_pipe();
    write_reg(REG_ADJUST_ENABLE, 32'(ae));
    write_reg(REG_CONTRAST, 32'(cp));
    write_reg(REG_BRIGHTNESS, 32'(bo));
    write_reg(REG_GAMMA_ENABLE, 32'(ge));
  endtask

  task automatic test_reset_defaults();
    send_pixel(8'd0, 16'h0000, 16'h0000, 1'b0);
    send_pixel(8'd255, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(8'd128, 16'h0000, 16'hFFFF, 1'b1);
    send_pixel(8'd127, 16'hFFFF, 16'h0000, 1'b1);
    send_pixel(8'd64, 16'h5A5A, 16'hA5A5, 1'b0);
    send_pixel(8'd192, 16'h1234, 16'h8001, 1'b1);
  endtask

  task automatic test_adjust_corners();
    set_config(1'b0, 9'd115, 9'd0, 1'b0);
    send_pixel(8'd255, 16'h0001, 16'h0002, 1'b0);
    send_pixel(8'd63, 16'hFFFF, 16'hFFFF, 1'b1);
    set_config(1'b1, 9'd0, 9'd0, 1'b0);
    send_pixel(8'd200, 16'h04D2, 16'h10E1, 1'b1);
    set_config(1'b1, 9'd511, 9'd0, 1'b0);
    send_pixel(8'd130, 16'h0007, 16'h0009, 1'b0);
    send_pixel(8'd60, 16'h7FFF, 16'h8000, 1'b1);
    set_config(1'b1, 9'd100, 9'h100, 1'b0);       // brightness -256
    send_pixel(8'd255, 16'h0100, 16'h0200, 1'b0);
    set_config(1'b1, 9'd100, 9'd255, 1'b0);
    send_pixel(8'd1, 16'h0033, 16'h0044, 1'b1);
    set_config(1'b1, 9'd100, 9'd0, 1'b1);
    send_pixel(8'd0, 16'h0000, 16'h0000, 1'b0);   // gamma keeps zero
    send_pixel(8'd1, 16'h0010, 16'h0020, 1'b1);
    send_pixel(8'd255, 16'hFFFF, 16'h0000, 1'b0);
    send_pixel(8'd100, 16'hABCD, 16'hEF01, 1'b1);
    set_config(1'b1, 9'd400, 9'h101, 1'b1);       // brightness -255
    send_pixel(8'd255, 16'h0F0F, 16'hF0F0, 1'b1);
  endtask

  task automatic send_random_pixel();
    logic [7:0]  g;
    logic [15:0] x;
    logic [15:0] y;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    else if (pick == 1) g = 8'($urandom_range(118, 138));
    else g = 8'($urandom);
    x = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom);
    y = ($urandom_range(0, 19) == 0) ? 16'h0000 : 16'($urandom);
    send_pixel(g, x, y, 1'($urandom));
  endtask

  task automatic test_random_phases();
    logic [8:0] cp;
    logic [8:0] bo;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_config(1'b1, 9'd0, 9'h100, 1'b0);
        1: set_config(1'b1, 9'd511, 9'd255, 1'b1);
        2: set_config(1'b0, 9'($urandom), 9'($urandom), 1'($urandom));
        default: begin
          cp = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(60, 180));
          bo = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 80) - 40);
          set_config($urandom_range(0, 4) != 0, cp, bo, 1'($urandom));
        end
      endcase
      calm = (ph % 4 == 3);
      repeat (75) send_random_pixel();
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_adjust_corners();
    test_random_phases();
    drain_pipe();
    if (level_q.size() != 0)
      report_mismatch($sformatf("%0d levels never arrived", level_q.size()));
    if (err_cnt == 0) begin
      $display("PASS gray_adjust_two_bit_quantizer");
    end else begin
      $display("FAIL gray_adjust_two_bit_quantizer");
    end
    $finish;
  end

endmodule
